// ===== rtl/mpas_pkg.sv =====
// Package for the median-fed adaptive smoother.
// Holds widths, register indexes, Q-format constants and the controller command struct.
// Depends on nothing.
package mpas_pkg;

    localparam int WINDOW_DEF = 5;
    localparam int DATA_W     = 32;
    localparam int STAB_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ASSIST = 2'd3;

    // Q1.16 coefficients
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [16:0] W_NEW      = 17'd3277;
    localparam logic [16:0] W_OLD      = 17'd62259;
    localparam logic [16:0] LOCK_FRAC  = 17'd6554;
    localparam logic [16:0] TRACK_FRAC = 17'd19661;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_SORT   = 4'd1;
    localparam logic [3:0] OP_ERR    = 4'd2;
    localparam logic [3:0] OP_TREND  = 4'd3;
    localparam logic [3:0] OP_MODE   = 4'd4;
    localparam logic [3:0] OP_DIV    = 4'd5;
    localparam logic [3:0] OP_INTEG  = 4'd6;
    localparam logic [3:0] OP_PROP_A = 4'd7;
    localparam logic [3:0] OP_PROP_B = 4'd8;
    localparam logic [3:0] OP_OUT    = 4'd9;
    localparam logic [3:0] OP_PRIME  = 4'd10;
    localparam logic [3:0] OP_RAW    = 4'd11;

    typedef struct packed {
        logic       load;   // write sample into window
        logic [3:0] op;
    } mpas_cmd_t;

    typedef struct packed {
        logic full;         // window full after this load
        logic primed;
        logic step_done;    // multi-cycle op finished
    } mpas_stat_t;

    // round half up, then arithmetic shift by 16
    function automatic logic signed [63:0] shr16r(input logic signed [63:0] v);
        logic signed [63:0] w;
        begin
            w = v + 64'sd32768;
            shr16r = w >>> 16;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                sat32 = 32'h7fff_ffff;
            else if (v < -64'sd2147483648)
                sat32 = 32'h8000_0000;
            else
                sat32 = v[31:0];
        end
    endfunction

endpackage

// ===== rtl/mpas_if.sv =====
// Valid/ready channel carrying a packed payload word.
// Depends on nothing.
interface mpas_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mpas_ctrl.sv =====
// Controller state machine for the smoother: sequences window load, median
// sort, filter update steps and result hand-off. Depends on mpas_pkg.
module mpas_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mpas_pkg::mpas_stat_t stat,
    output mpas_pkg::mpas_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SORT  = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_TREND = 4'd3;
    localparam logic [3:0] S_MODE  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_INTEG = 4'd6;
    localparam logic [3:0] S_PROPA = 4'd7;
    localparam logic [3:0] S_PROPB = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_PRIME = 4'd10;
    localparam logic [3:0] S_RAW   = 4'd11;
    localparam logic [3:0] S_HOLD  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       accept;

    // input taken only in the idle state and when no result is pending in the output register
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        cmd.load   = accept;
        cmd.op     = mpas_pkg::OP_NONE;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_HOLD;
            S_HOLD:
            begin
                if (!stat.full)       state_next = S_RAW;
                else                  state_next = S_SORT;
            end
            S_SORT:
            begin
                cmd.op = mpas_pkg::OP_SORT;
                if (stat.step_done)
                    state_next = stat.primed ? S_ERR : S_PRIME;
            end
            S_ERR:   begin cmd.op = mpas_pkg::OP_ERR;   state_next = S_TREND; end
            S_TREND: begin cmd.op = mpas_pkg::OP_TREND; state_next = S_MODE;  end
            S_MODE:  begin cmd.op = mpas_pkg::OP_MODE;  state_next = S_DIV;   end
            S_DIV:
            begin
                cmd.op = mpas_pkg::OP_DIV;
                if (stat.step_done) state_next = S_INTEG;
            end
            S_INTEG: begin cmd.op = mpas_pkg::OP_INTEG; state_next = S_PROPA; end
            S_PROPA: begin cmd.op = mpas_pkg::OP_PROP_A; state_next = S_PROPB; end
            S_PROPB: begin cmd.op = mpas_pkg::OP_PROP_B; state_next = S_OUT;   end
            S_OUT:
            begin
                cmd.op = mpas_pkg::OP_OUT; state_next = S_IDLE; ov_next = 1'b1;
            end
            S_PRIME:
            begin
                cmd.op = mpas_pkg::OP_PRIME; state_next = S_IDLE; ov_next = 1'b1;
            end
            S_RAW:
            begin
                cmd.op = mpas_pkg::OP_RAW; state_next = S_IDLE; ov_next = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

// ===== rtl/mpas_dp.sv =====
// Datapath for the smoother: window, iterative median sort, serial divider,
// trend, mode, integral and EMA registers. Depends on mpas_pkg.
module mpas_dp #(
    parameter int WINDOW = mpas_pkg::WINDOW_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mpas_pkg::mpas_cmd_t                  cmd,
    output mpas_pkg::mpas_stat_t                 stat,
    input  logic signed [mpas_pkg::DATA_W-1:0]   sample,
    input  logic                                 cfg_we,
    input  logic [mpas_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [mpas_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [mpas_pkg::DATA_W-1:0]   filtered,
    output logic [mpas_pkg::STAB_W-1:0]          stability,
    output logic                                 locked,
    output logic                                 primed
);
    localparam int WIN_LEN = WINDOW | 1;
    localparam int IDX_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
    localparam int CNT_W   = $clog2(WIN_LEN + 1);
    localparam int MID     = WIN_LEN / 2;

    // configuration registers
    logic [30:0] settle_reg;
    logic [16:0] lock_a_reg, track_a_reg, assist_reg;

    // window and sort scratch (odd-even transposition, one pass a cycle)
    logic signed [31:0] win_reg [WIN_LEN];
    logic signed [31:0] srt_reg [WIN_LEN];
    logic [IDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   pass_reg;
    logic               sort_busy_reg;

    // filter state
    logic               primed_reg;
    logic signed [31:0] prop_reg, integ_reg, res_reg;
    logic [30:0]        trend_reg;
    logic               lock_reg;
    logic [16:0]        stab_reg;

    // step temporaries
    logic signed [32:0] err_reg;
    logic [32:0]        mag_reg;
    logic signed [63:0] pa_reg;

    // serial divider: (trend << 16) / settle, 17 quotient bits suffice
    logic [47:0]        rem_reg;
    logic [16:0]        quo_reg;
    logic [4:0]         dcnt_reg;
    logic               div_busy_reg;
    logic [16:0]        quo_fin;

    logic signed [31:0] med;
    logic [16:0]        alpha;
    logic signed [63:0] st64;

    // combinational step results
    logic signed [63:0] trend_sum;
    logic [30:0]        trend_sat;
    logic signed [63:0] it_sum;
    logic signed [31:0] it_clamp;
    logic signed [63:0] pb_prod;

    assign med  = srt_reg[MID];
    assign st64 = {33'd0, settle_reg};
    always_comb
    begin
        if (lock_reg)
            alpha = (lock_a_reg > mpas_pkg::ONE_Q16) ? mpas_pkg::ONE_Q16 : lock_a_reg;
        else
            alpha = (track_a_reg > mpas_pkg::ONE_Q16) ? mpas_pkg::ONE_Q16 : track_a_reg;
    end

    assign stat.full      = (fill_reg == CNT_W'(WIN_LEN));
    assign stat.primed    = primed_reg;
    assign stat.step_done = (cmd.op == mpas_pkg::OP_SORT) ? (sort_busy_reg &&
                            pass_reg == CNT_W'(WIN_LEN - 1)) :
                            (div_busy_reg && dcnt_reg == 5'd16);

    assign filtered  = res_reg;
    assign stability = stab_reg;
    assign locked    = lock_reg;
    assign primed    = primed_reg;

    // final quotient: last bit from the remainder, clamped to one
    always_comb
    begin
        quo_fin = quo_reg | {16'd0, (rem_reg >= {17'd0, settle_reg})};
        if (quo_fin > mpas_pkg::ONE_Q16)
            quo_fin = mpas_pkg::ONE_Q16;
    end

    // window memory and sort network
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            win_reg[head_reg] <= sample;
        if (cmd.op == mpas_pkg::OP_SORT)
        begin
            if (!sort_busy_reg)
            begin
                for (int k = 0; k < WIN_LEN; k++)
                    srt_reg[k] <= win_reg[k];
            end
            else
            begin
                for (int k = 0; k + 1 < WIN_LEN; k++)
                begin
                    if ((k % 2) == int'(pass_reg[0]) && srt_reg[k] > srt_reg[k+1])
                    begin
                        srt_reg[k]   <= srt_reg[k+1];
                        srt_reg[k+1] <= srt_reg[k];
                    end
                end
            end
        end
    end

    // control-ish registers and filter math
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg    <= 31'd65536;
            lock_a_reg    <= 17'd3277;
            track_a_reg   <= 17'd32768;
            assist_reg    <= 17'd6554;
            head_reg      <= '0;
            fill_reg      <= '0;
            pass_reg      <= '0;
            sort_busy_reg <= 1'b0;
            primed_reg    <= 1'b0;
            prop_reg      <= '0;
            integ_reg     <= '0;
            trend_reg     <= '0;
            lock_reg      <= 1'b0;
            stab_reg      <= '0;
            div_busy_reg  <= 1'b0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                primed_reg <= 1'b0;
                unique case (cfg_idx)
                    mpas_pkg::REG_SETTLE:  settle_reg  <= cfg_data;
                    mpas_pkg::REG_LOCK_A:  lock_a_reg  <= cfg_data[16:0];
                    mpas_pkg::REG_TRACK_A: track_a_reg <= cfg_data[16:0];
                    mpas_pkg::REG_ASSIST:  assist_reg  <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                head_reg <= (head_reg == IDX_W'(WIN_LEN - 1)) ? '0 : head_reg + 1'b1;
                if (fill_reg != CNT_W'(WIN_LEN))
                    fill_reg <= fill_reg + 1'b1;
            end
            case (cmd.op)
                mpas_pkg::OP_SORT:
                begin
                    if (!sort_busy_reg)
                    begin
                        sort_busy_reg <= 1'b1;
                        pass_reg      <= '0;
                    end
                    else if (pass_reg == CNT_W'(WIN_LEN - 1))
                        sort_busy_reg <= 1'b0;
                    else
                        pass_reg <= pass_reg + 1'b1;
                end
                mpas_pkg::OP_PRIME:
                begin
                    prop_reg   <= med;
                    integ_reg  <= '0;
                    primed_reg <= 1'b1;
                end
                mpas_pkg::OP_MODE:
                begin
                    if (!lock_reg && {33'd0, trend_reg} <
                        mpas_pkg::shr16r(st64 * $signed({47'd0, mpas_pkg::LOCK_FRAC})))
                    begin
                        lock_reg  <= 1'b1;
                        integ_reg <= '0;
                    end
                    else if (lock_reg && {33'd0, trend_reg} >
                             mpas_pkg::shr16r(st64 * $signed({47'd0, mpas_pkg::TRACK_FRAC})))
                        lock_reg <= 1'b0;
                end
                mpas_pkg::OP_DIV:
                begin
                    if (!div_busy_reg)
                    begin
                        div_busy_reg <= 1'b1;
                        dcnt_reg     <= '0;
                    end
                    else if (dcnt_reg == 5'd16)
                    begin
                        div_busy_reg <= 1'b0;
                        if (settle_reg == '0)
                            stab_reg <= '0;
                        else
                            stab_reg <= mpas_pkg::ONE_Q16 - quo_fin;
                    end
                    else
                        dcnt_reg <= dcnt_reg + 1'b1;
                end
                mpas_pkg::OP_INTEG:
                begin
                    if (!lock_reg)
                        integ_reg <= it_clamp;
                end
                mpas_pkg::OP_PROP_B:
                    prop_reg <= mpas_pkg::sat32(mpas_pkg::shr16r(pa_reg + pb_prod));
                mpas_pkg::OP_TREND:
                    trend_reg <= trend_sat;
                default: ;
            endcase
        end
    end

    // trend update: a 33x17 and a 31x17 product summed
    always_comb
    begin
        trend_sum = mpas_pkg::shr16r(
            $signed({31'd0, mag_reg}) * $signed({47'd0, mpas_pkg::W_NEW}) +
            $signed({33'd0, trend_reg}) * $signed({47'd0, mpas_pkg::W_OLD}));
        trend_sat = (trend_sum > 64'sd2147483647) ? 31'h7fff_ffff : trend_sum[30:0];
    end

    // integral step with clamp to +/- settle
    always_comb
    begin
        it_sum = 64'(integ_reg) + mpas_pkg::shr16r(64'(err_reg) * $signed({47'd0, assist_reg}));
        if (it_sum > st64)
            it_clamp = $signed({1'b0, settle_reg});
        else if (it_sum < -st64)
            it_clamp = -$signed({1'b0, settle_reg});
        else
            it_clamp = it_sum[31:0];
    end

    assign pb_prod = $signed({47'd0, mpas_pkg::ONE_Q16 - alpha}) * 64'(prop_reg);

    // payload temporaries and divider datapath
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            mpas_pkg::OP_ERR:
            begin
                err_reg <= 33'(med) - 33'(prop_reg);
                mag_reg <= (33'(med) < 33'(prop_reg)) ? 33'(prop_reg) - 33'(med) :
                                                        33'(med) - 33'(prop_reg);
            end
            mpas_pkg::OP_DIV:
            begin
                if (!div_busy_reg)
                begin
                    rem_reg <= {1'b0, trend_reg, 16'd0};
                    quo_reg <= '0;
                end
                else if (dcnt_reg != 5'd16)
                begin
                    // restoring division: bit 16 down to 1 probed each cycle
                    if (rem_reg >= ({17'd0, settle_reg} << (5'd16 - dcnt_reg)))
                    begin
                        rem_reg <= rem_reg - ({17'd0, settle_reg} << (5'd16 - dcnt_reg));
                        quo_reg <= quo_reg | (17'd1 << (5'd16 - dcnt_reg));
                    end
                end
                else
                    quo_reg <= quo_fin;
            end
            mpas_pkg::OP_PROP_A:
                pa_reg <= $signed({47'd0, alpha}) * 64'(med);
            mpas_pkg::OP_OUT:
                res_reg <= mpas_pkg::sat32(64'(prop_reg) + 64'(integ_reg));
            mpas_pkg::OP_PRIME:
                res_reg <= med;
            mpas_pkg::OP_RAW:
                res_reg <= win_reg[(head_reg == '0) ? IDX_W'(WIN_LEN - 1) : head_reg - 1'b1];
            default: ;
        endcase
    end
endmodule

// ===== rtl/median_pi_adaptive_smoother_unit.sv =====
// Top level of the median-fed adaptive smoother.
// Depends on mpas_pkg, mpas_if, mpas_ctrl and mpas_dp.
//
//  channel  | dir | payload                                   | handshake
//  in_ch    | in  | sample[31:0]                              | valid/ready
//  out_ch   | out | primed[50], locked[49], stability[48:32], filtered[31:0] | valid/ready
//  cfg      | in  | cfg_we, cfg_idx[1:0], cfg_data[30:0]      | write on cfg_we
//
// One word at a time; L = WINDOW | 1. Before the window fills, the input word goes
// straight to the result; on priming, the window is sorted (sort load plus L passes)
// and its median becomes the result; a filter step sorts, then runs error, trend,
// mode, the serial divider, integral and two EMA steps before the result is formed.
// The result sits in an output register; a new word is taken the cycle after
// that result has left. Reset clears control and filter state except the output register.
module median_pi_adaptive_smoother_unit #(
    parameter int WINDOW = mpas_pkg::WINDOW_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mpas_if.sink                                 in_ch,
    mpas_if.source                               out_ch,
    input  logic                                 cfg_we,
    input  logic [mpas_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [mpas_pkg::CFG_DATA_W-1:0]      cfg_data
);
    mpas_pkg::mpas_cmd_t  cmd;
    mpas_pkg::mpas_stat_t stat;
    logic signed [31:0]   filtered;
    logic [16:0]          stability;
    logic                 locked, primed;

    mpas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mpas_dp #(.WINDOW(WINDOW)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .sample    (in_ch.data[31:0]),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .filtered  (filtered),
        .stability (stability),
        .locked    (locked),
        .primed    (primed)
    );

    assign out_ch.data = {primed, locked, stability, filtered};
endmodule

// ===== test/testbench.sv =====
// Testbench for median_pi_adaptive_smoother_unit: random and directed samples with checking.
// A scoreboard class predicts every result word and compares it field by field.
// Depends on mpas_pkg, mpas_if and the RTL top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_LEN = mpas_pkg::WINDOW_DEF | 1;
    localparam int OUT_W = 51;
    localparam int DRAIN_CYCLES = 60;

    // one predicted result word
    typedef struct {
        logic signed [31:0] filtered;
        logic [16:0]        stability;
        logic               locked;
        logic               primed;
    } smooth_word_t;

    class smoother_scoreboard;
        // configuration copy
        longint settle;
        longint lock_alpha;
        longint track_alpha;
        longint assist_gain;
        // filter state copy
        logic signed [31:0] win [WIN_LEN];
        int     head;
        int     fill;
        bit     primed;
        longint prop;
        longint integ;
        longint trend;
        bit     locked;
        longint stab;
        smooth_word_t pending [$];
        int     mismatches;
        int     words_checked;
        int     lock_words;

        function new();
            settle = 65536;
            lock_alpha = 3277;
            track_alpha = 32768;
            assist_gain = 6554;
            head = 0;
            fill = 0;
            primed = 0;
            prop = 0;
            integ = 0;
            trend = 0;
            locked = 0;
            stab = 0;
            mismatches = 0;
            words_checked = 0;
            lock_words = 0;
            foreach (win[k]) win[k] = '0;
        endfunction

        function longint rnd16(longint v);
            longint w;
            w = v + 32768;
            return w >>> 16;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint median_of_window();
            longint s [WIN_LEN];
            longint t;
            foreach (win[k]) s[k] = longint'(win[k]);
            for (int a = 1; a < WIN_LEN; a++)
                for (int b = a; b > 0 && s[b-1] > s[b]; b--)
                begin
                    t = s[b];
                    s[b] = s[b-1];
                    s[b-1] = t;
                end
            return s[WIN_LEN/2];
        endfunction

        function void write_reg(logic [mpas_pkg::CFG_IDX_W-1:0] idx,
                                logic [mpas_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mpas_pkg::REG_SETTLE:  settle = longint'(data);
                mpas_pkg::REG_LOCK_A:  lock_alpha = longint'(data[16:0]);
                mpas_pkg::REG_TRACK_A: track_alpha = longint'(data[16:0]);
                mpas_pkg::REG_ASSIST:  assist_gain = longint'(data[16:0]);
                default: ;
            endcase
            primed = 0;
        endfunction

        // predict the word caused by one accepted sample
        function void note_sample(logic signed [31:0] sample);
            smooth_word_t w;
            longint med, err, mag, lthr, tthr, alpha, norm, it, res;
            win[head] = sample;
            head = (head + 1) % WIN_LEN;
            if (fill < WIN_LEN) fill++;
            if (!primed) begin
                if (fill < WIN_LEN)
                    res = longint'(sample);
                else begin
                    prop = median_of_window();
                    integ = 0;
                    primed = 1;
                    res = prop;
                end
            end else begin
                med = median_of_window();
                err = med - prop;
                mag = err < 0 ? -err : err;
                lthr = rnd16(settle * 6554);
                tthr = rnd16(settle * 19661);
                trend = rnd16(mag * 3277 + trend * 62259);
                if (trend > 64'sd2147483647) trend = 64'sd2147483647;
                if (!locked && trend < lthr) begin
                    locked = 1;
                    integ = 0;
                end else if (locked && trend > tthr)
                    locked = 0;
                if (settle == 0)
                    norm = 65536;
                else begin
                    norm = (trend * 65536) / settle;
                    if (norm > 65536) norm = 65536;
                end
                stab = 65536 - norm;
                if (locked)
                    alpha = lock_alpha > 65536 ? 65536 : lock_alpha;
                else begin
                    alpha = track_alpha > 65536 ? 65536 : track_alpha;
                    it = integ + rnd16(err * assist_gain);
                    if (it > settle) it = settle;
                    if (it < -settle) it = -settle;
                    integ = it;
                end
                prop = clip32(rnd16(alpha * med + (65536 - alpha) * prop));
                res = clip32(prop + integ);
            end
            w.filtered = res[31:0];
            w.stability = stab[16:0];
            w.locked = locked;
            w.primed = primed;
            pending.insert(pending.size(), w);
        endfunction

        function void check_word(logic [OUT_W-1:0] word);
            smooth_word_t e;
            bit bad;
            words_checked++;
            if (word[49]) lock_words++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", word);
                return;
            end
            e = pending.pop_front();
            bad = (word[31:0] !== e.filtered) || (word[48:32] !== e.stability) ||
                  (word[49] !== e.locked) || (word[50] !== e.primed);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: exp filt=%h stab=%0d lock=%b prim=%b, %s",
                             words_checked, e.filtered, e.stability, e.locked, e.primed,
                             $sformatf("got filt=%h stab=%0d lock=%b prim=%b",
                                       word[31:0], word[48:32], word[49], word[50]));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [mpas_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [mpas_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    bit hold_out = 0;
    int samples_sent = 0;
    smoother_scoreboard sb = new();

    mpas_if #(.W(mpas_pkg::DATA_W)) in_ch ();
    mpas_if #(.W(OUT_W))            out_ch ();

    median_pi_adaptive_smoother_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // result receiver with random stalls and an optional long hold
    initial
    begin
        int gap;
        gap = 0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                sb.check_word(out_ch.data);
                gap = $urandom_range(0, 8);
            end
            out_ch.ready <= (gap == 0) && !hold_out && rst_n;
            if (gap > 0) gap--;
        end
    end

    // long receiver hold so the block backs up its input
    initial
    begin
        wait (samples_sent == 300);
        hold_out = 1;
        repeat (400) @(posedge clk);
        hold_out = 0;
    end

    task automatic send_sample(logic signed [31:0] s);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= s;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_sample(s);
        samples_sent++;
    endtask

    // wait until every word is back, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (sb.pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [mpas_pkg::CFG_IDX_W-1:0] idx,
                             logic [mpas_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // noisy samples around a level, with some full-range words mixed in
    task automatic noisy_run(int count, longint level, longint spread);
        longint v;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                v = longint'($signed($urandom()));
            else
                v = level + longint'($urandom_range(0, 32'(spread))) - spread / 2;
            send_sample(v[31:0]);
        end
    endtask

    initial
    begin
        longint lvl, spr;
        logic [mpas_pkg::CFG_DATA_W-1:0] d;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes through fill, priming and filtering
        send_sample(32'sh7fffffff);
        send_sample(32'sh80000000);
        send_sample(32'sh00000000);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(32'sh7fffffff);
        send_sample(32'sh7fffffff);
        send_sample(32'sh80000000);
        send_sample(32'sh80000000);
        send_sample(32'sh80000000);
        send_sample(32'sh00010000);
        send_sample(32'sh00010000);
        drain();
        // zero settle threshold, alphas above one, re-prime on write
        write_reg(mpas_pkg::REG_SETTLE, '0);
        write_reg(mpas_pkg::REG_LOCK_A, 31'h1ffff);
        write_reg(mpas_pkg::REG_TRACK_A, 31'h1ffff);
        write_reg(mpas_pkg::REG_ASSIST, 31'h1ffff);
        for (int n = 0; n < 8; n++) send_sample(32'(n * 40000 - 100000));
        drain();

        // random phases with several register settings
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: d = 31'd65536;
                1: d = 31'h7fffffff;
                2: d = '0;
                default: d = 31'($urandom_range(0, 32'h0100_0000));
            endcase
            if (ph == 8) d = 31'($urandom());
            write_reg(mpas_pkg::REG_SETTLE, d);
            write_reg(mpas_pkg::REG_LOCK_A,
                      ph == 1 ? 31'd0 : 31'($urandom_range(0, 70000)));
            write_reg(mpas_pkg::REG_TRACK_A,
                      ph == 1 ? 31'd65536 : 31'($urandom_range(0, 70000)));
            write_reg(mpas_pkg::REG_ASSIST,
                      ph == 2 ? 31'd0 : 31'($urandom_range(0, 131071)));
            if ($urandom_range(0, 1)) write_reg(2'($urandom_range(0, 3)), 31'($urandom()));
            for (int seg = 0; seg < 4; seg++)
            begin
                lvl = longint'($signed($urandom())) / (1 << $urandom_range(0, 16));
                spr = longint'(sb.settle) >> $urandom_range(0, 6);
                if (spr == 0 || spr > 64'h7fff_ffff) spr = $urandom_range(1, 32'h0001_0000);
                noisy_run(28, lvl, spr);
            end
            drain();
        end

        $display("checked %0d result words (%0d locked) over %0d samples and 11 register settings",
                 sb.words_checked, sb.lock_words, samples_sent);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches, %0d words missing", sb.mismatches, sb.pending.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // run time limit
    initial
    begin
        #10ms;
        $display("timeout with %0d words outstanding", sb.pending.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/mpas_pkg.sv
rtl/mpas_if.sv
rtl/mpas_ctrl.sv
rtl/mpas_dp.sv
rtl/median_pi_adaptive_smoother_unit.sv
test/testbench.sv
